// File: rtl/ocft_pkg.sv
// Shared widths, register codes, configuration and control types for the
// overcurrent filter and trip latch. No dependencies.
`default_nettype none

package ocft_pkg;

   localparam int AdcBits = 12;

   localparam int TimeW   = 32;
   localparam int SampleW = 12;
   localparam int AccW    = 16;
   localparam int CurW    = 24;
   localparam int PeriodW = 16;
   localparam int ShiftW  = 4;
   localparam int VrefW   = 13;
   localparam int FsW     = 12;
   localparam int GainW   = 8;
   localparam int ShuntW  = 20;

   localparam int ScaleW  = 20;
   localparam int ProdAW  = SampleW + VrefW;
   localparam int ProdBW  = FsW + GainW;
   localparam int NumW    = ProdAW + ScaleW;
   localparam int DenW    = ProdBW + ShuntW;
   localparam int DvdW    = 48;
   localparam int DivCntW = $clog2(DvdW);
   localparam int DeltaW  = AccW + 2;

   localparam logic [ScaleW-1:0]  MicroScale = ScaleW'(1000000);
   localparam logic [SampleW-1:0] LevelMask  = SampleW'((64'd1 << AdcBits) - 64'd1);
   localparam logic [CurW-1:0]    CurrentMax = {CurW{1'b1}};

   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;

   localparam logic [2:0] RegSamplePeriod = 3'd0;
   localparam logic [2:0] RegFilterShift  = 3'd1;
   localparam logic [2:0] RegTripCurrent  = 3'd2;
   localparam logic [2:0] RegVref         = 3'd3;
   localparam logic [2:0] RegFullScale    = 3'd4;
   localparam logic [2:0] RegSenseGain    = 3'd5;
   localparam logic [2:0] RegShunt        = 3'd6;
   localparam logic [2:0] RegProtect      = 3'd7;

   typedef struct packed {
      logic [PeriodW-1:0] sample_period_ms;
      logic [ShiftW-1:0]  filter_shift;
      logic [CurW-1:0]    trip_current_ma;
      logic [VrefW-1:0]   vref_mv;
      logic [FsW-1:0]     adc_full_scale;
      logic [GainW-1:0]   sense_gain;
      logic [ShuntW-1:0]  shunt_micro_ohm;
      logic               protect_enable;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic check;
      logic filt;
      logic mul1;
      logic mul2;
      logic add;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic due;
      logic ok;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/ocft_if.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on ocft_pkg for field widths.
`default_nettype none

interface ocft_req_if import ocft_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [TimeW-1:0]   time_ms;
   logic               conversion_ok;
   logic [SampleW-1:0] adc_sample;

   modport source (output valid, output time_ms, output conversion_ok,
                   output adc_sample, input ready);
   modport sink   (input valid, input time_ms, input conversion_ok,
                   input adc_sample, output ready);
endinterface

interface ocft_rsp_if import ocft_pkg::*; ;
   logic               valid;
   logic               ready;
   logic               sample_taken;
   logic [SampleW-1:0] last_raw;
   logic [AccW-1:0]    filtered_level_q4;
   logic [CurW-1:0]    current_ma;
   logic               fault_latched;

   modport source (output valid, output sample_taken, output last_raw,
                   output filtered_level_q4, output current_ma,
                   output fault_latched, input ready);
   modport sink   (input valid, input sample_taken, input last_raw,
                   input filtered_level_q4, input current_ma,
                   input fault_latched, output ready);
endinterface

`default_nettype wire

// File: rtl/ocft_csr.sv
// Configuration register file on an APB-style port.
// Depends on ocft_pkg for register codes and the cfg_type struct.
`default_nettype none

module ocft_csr import ocft_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CsrAddrW-1:0] paddr,
   input  wire logic [CsrDataW-1:0] pwdata,
   output logic      [CsrDataW-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index  = paddr[CsrAddrW-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            RegSamplePeriod: cfg_in.sample_period_ms = pwdata[PeriodW-1:0];
            RegFilterShift:  cfg_in.filter_shift     = pwdata[ShiftW-1:0];
            RegTripCurrent:  cfg_in.trip_current_ma  = pwdata[CurW-1:0];
            RegVref:         cfg_in.vref_mv          = pwdata[VrefW-1:0];
            RegFullScale:    cfg_in.adc_full_scale   = pwdata[FsW-1:0];
            RegSenseGain:    cfg_in.sense_gain       = pwdata[GainW-1:0];
            RegShunt:        cfg_in.shunt_micro_ohm  = pwdata[ShuntW-1:0];
            RegProtect:      cfg_in.protect_enable   = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         RegSamplePeriod: prdata = CsrDataW'(cfg_ff.sample_period_ms);
         RegFilterShift:  prdata = CsrDataW'(cfg_ff.filter_shift);
         RegTripCurrent:  prdata = CsrDataW'(cfg_ff.trip_current_ma);
         RegVref:         prdata = CsrDataW'(cfg_ff.vref_mv);
         RegFullScale:    prdata = CsrDataW'(cfg_ff.adc_full_scale);
         RegSenseGain:    prdata = CsrDataW'(cfg_ff.sense_gain);
         RegShunt:        prdata = CsrDataW'(cfg_ff.shunt_micro_ohm);
         RegProtect:      prdata = CsrDataW'(cfg_ff.protect_enable);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period_ms <= PeriodW'(10);
         cfg_ff.filter_shift     <= ShiftW'(3);
         cfg_ff.trip_current_ma  <= CurW'(2000);
         cfg_ff.vref_mv          <= VrefW'(3300);
         cfg_ff.adc_full_scale   <= FsW'(4095);
         cfg_ff.sense_gain       <= GainW'(50);
         cfg_ff.shunt_micro_ohm  <= ShuntW'(10000);
         cfg_ff.protect_enable   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ocft_ctrl.sv
// Sequencer for one request: period check; if a sample is taken, filter, scaling
// multiplies and bit-serial division; then response hand-off. Depends on ocft_pkg.
`default_nettype none

module ocft_ctrl import ocft_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  status_type      status,
   output cmd_type         cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_FILT  = 3'd2;
   localparam logic [2:0] S_MUL1  = 3'd3;
   localparam logic [2:0] S_MUL2  = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               valid_ff, valid_in;
   logic               slot_free;

   assign slot_free = ~valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff & ~rsp_ready;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = (status.due & status.ok) ? S_FILT : S_DONE;
         end
         S_FILT: begin
            cmd.filt = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DivCntW'(DvdW - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ocft_datapath.sv
// Datapath: sample timing, exponential filter, current scaling with a
// restoring divider, fault latch and response registers. Depends on ocft_pkg.
`default_nettype none

module ocft_datapath import ocft_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  cfg_type                 cfg,
   input  cmd_type                 cmd,
   output status_type              status,
   input  wire logic [TimeW-1:0]   time_ms,
   input  wire logic               conversion_ok,
   input  wire logic [SampleW-1:0] adc_sample,
   output logic                    sample_taken,
   output logic      [SampleW-1:0] last_raw,
   output logic      [AccW-1:0]    filtered_level_q4,
   output logic      [CurW-1:0]    current_ma,
   output logic                    fault_latched
);

   logic [TimeW-1:0]   time_ff;
   logic               ok_ff;
   logic [SampleW-1:0] sample_ff;
   logic [TimeW-1:0]   last_time_ff;
   logic [AccW-1:0]    acc_ff;
   logic               seeded_ff;
   logic [SampleW-1:0] raw_ff;
   logic [CurW-1:0]    cur_ff;
   logic               fault_ff;
   logic               taken_ff;
   logic [ProdAW-1:0]  prod_a_ff;
   logic [ProdBW-1:0]  prod_b_ff;
   logic [NumW-1:0]    num_ff;
   logic [DenW-1:0]    den_ff;
   logic [DvdW-1:0]    dvd_ff;
   logic [DenW-1:0]    rem_ff;

   logic               out_taken_ff;
   logic [SampleW-1:0] out_raw_ff;
   logic [AccW-1:0]    out_acc_ff;
   logic [CurW-1:0]    out_cur_ff;
   logic               out_fault_ff;

   logic [TimeW-1:0]   elapsed;
   logic [AccW-1:0]    target;
   logic [DeltaW-1:0]  delta;
   logic [DeltaW-1:0]  bias;
   logic [DeltaW-1:0]  step;
   logic [DeltaW-1:0]  acc_sum;
   logic [SampleW-1:0] level;
   logic [DenW:0]      rem_sh;
   logic               ge;
   logic [DenW:0]      rem_diff;
   logic [CurW-1:0]    cur_in;
   logic               fault_in;

   assign elapsed    = time_ff - last_time_ff;
   assign status.due = (elapsed >= TimeW'(cfg.sample_period_ms));
   assign status.ok  = ok_ff;

   assign target  = {sample_ff, 4'b0000};
   assign delta   = {2'b00, target} - {2'b00, acc_ff};
   assign bias    = delta[DeltaW-1] ? ((DeltaW'(1) << cfg.filter_shift) - DeltaW'(1)) : '0;
   assign step    = DeltaW'($signed(delta + bias) >>> cfg.filter_shift);
   assign acc_sum = {2'b00, acc_ff} + step;
   assign level   = acc_ff[AccW-1:4] & LevelMask;

   assign rem_sh   = {rem_ff, dvd_ff[DvdW-1]};
   assign ge       = (rem_sh >= {1'b0, den_ff});
   assign rem_diff = rem_sh - {1'b0, den_ff};

   always_comb begin
      cur_in = cur_ff;
      if (taken_ff) begin
         if (den_ff == '0) begin
            cur_in = '0;
         end else if (|dvd_ff[DvdW-1:CurW]) begin
            cur_in = CurrentMax;
         end else begin
            cur_in = dvd_ff[CurW-1:0];
         end
      end
      fault_in = fault_ff |
                 (taken_ff & cfg.protect_enable & (cur_in >= cfg.trip_current_ma));
      if (!cfg.protect_enable) begin
         fault_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff   <= time_ms;
         ok_ff     <= conversion_ok;
         sample_ff <= adc_sample & LevelMask;
      end
      if (cmd.mul1) begin
         prod_a_ff <= ProdAW'(level) * ProdAW'(cfg.vref_mv);
         prod_b_ff <= ProdBW'(cfg.adc_full_scale) * ProdBW'(cfg.sense_gain);
      end
      if (cmd.mul2) begin
         num_ff <= NumW'(prod_a_ff) * NumW'(MicroScale);
         den_ff <= DenW'(prod_b_ff) * DenW'(cfg.shunt_micro_ohm);
      end
      if (cmd.add) begin
         dvd_ff <= DvdW'(num_ff) + DvdW'(den_ff >> 1);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DvdW-2:0], ge};
         rem_ff <= ge ? rem_diff[DenW-1:0] : rem_sh[DenW-1:0];
      end
      if (cmd.finish) begin
         out_taken_ff <= taken_ff;
         out_raw_ff   <= raw_ff;
         out_acc_ff   <= acc_ff;
         out_cur_ff   <= cur_in;
         out_fault_ff <= fault_in & cfg.protect_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         acc_ff       <= '0;
         seeded_ff    <= 1'b0;
         raw_ff       <= '0;
         cur_ff       <= '0;
         fault_ff     <= 1'b0;
         taken_ff     <= 1'b0;
      end else begin
         if (cmd.check) begin
            taken_ff <= status.due & ok_ff;
            if (status.due) begin
               last_time_ff <= time_ff;
            end
         end
         if (cmd.filt) begin
            raw_ff    <= sample_ff;
            seeded_ff <= 1'b1;
            acc_ff    <= seeded_ff ? acc_sum[AccW-1:0] : target;
         end
         if (cmd.finish) begin
            cur_ff   <= cur_in;
            fault_ff <= fault_in;
         end
      end
   end

   assign sample_taken      = out_taken_ff;
   assign last_raw          = out_raw_ff;
   assign filtered_level_q4 = out_acc_ff;
   assign current_ma        = out_cur_ff;
   assign fault_latched     = out_fault_ff;

endmodule

`default_nettype wire

// File: rtl/overcurrent_filter_trip_latch.sv
// When a sample is taken, a request goes through 5 setup steps, a 48-step restoring
// divider and the hand-off to response valid; otherwise it goes to the hand-off.
// A new request is accepted only once the last is handed off, which stalls for a
// free response slot; the next is accepted while a response waits to be taken.
// Reset (synchronous) clears filter, timing, current and fault state and loads
// register defaults. Depends on ocft_pkg, ocft_if, ocft_csr, ocft_ctrl, ocft_datapath.
`default_nettype none

module overcurrent_filter_trip_latch import ocft_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   ocft_req_if.sink                 req_chan,
   ocft_rsp_if.source               rsp_chan,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic      [CsrDataW-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   ocft_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ocft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ocft_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .time_ms           (req_chan.time_ms),
      .conversion_ok     (req_chan.conversion_ok),
      .adc_sample        (req_chan.adc_sample),
      .sample_taken      (rsp_chan.sample_taken),
      .last_raw          (rsp_chan.last_raw),
      .filtered_level_q4 (rsp_chan.filtered_level_q4),
      .current_ma        (rsp_chan.current_ma),
      .fault_latched     (rsp_chan.fault_latched)
   );

endmodule

`default_nettype wire
